// ===== sv/fsss_pkg.sv =====
package fsss_pkg;

  localparam int MAX_STAGES_DEF   = 8;
  localparam int BUFFER_BYTES_DEF = 256;

  localparam int COUNT_OFFSET = 2;
  localparam int TIMES_START  = 4;

  localparam logic [7:0] MARK_S = 8'h53;
  localparam logic [7:0] MARK_E = 8'h45;
  localparam logic [7:0] MARK_O = 8'h4F;
  localparam logic [7:0] MARK_F = 8'h46;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] FS_NONE   = 2'd0;
  localparam logic [1:0] FS_LOADED = 2'd1;
  localparam logic [1:0] FS_NO_SOF = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } fsss_req_t;

  typedef struct packed {
    logic [5:0] light_pattern;
    logic [2:0] stage_index;
    logic       stage_started;
    logic [1:0] frame_status;
    logic       schedule_loaded;
  } fsss_result_t;

  typedef struct packed {
    logic       load;
    logic [1:0] status;
  } fsss_frame_evt_t;

endpackage

// ===== sv/fsss_frame.sv =====
module fsss_frame
  import fsss_pkg::*;
#(
  parameter int MAX_STAGES   = MAX_STAGES_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_en,
  input  logic [7:0]                        rx_byte,
  output fsss_frame_evt_t                   evt,
  output logic [$clog2(MAX_STAGES+1)-1:0]   load_count,
  output logic [31:0]                       load_times    [MAX_STAGES],
  output logic [5:0]                        load_patterns [MAX_STAGES]
);

  localparam int PAT_START   = TIMES_START + 4 * MAX_STAGES;
  localparam int PAYLOAD_END = PAT_START + 4 * MAX_STAGES;
  localparam int OFF_W       = $clog2(PAYLOAD_END + 1);
  localparam int BH_W        = $clog2(BUFFER_BYTES + 1);
  localparam int CNT_W       = $clog2(MAX_STAGES + 1);

  logic [BH_W-1:0]  bytes_held;
  logic [15:0]      prior_two_bytes;
  logic             start_found;
  logic [OFF_W-1:0] payload_offset;
  logic [7:0]       pending_count;
  logic [31:0]      pending_times    [MAX_STAGES];
  logic [5:0]       pending_patterns [MAX_STAGES];

  logic             take;
  logic             cap;
  logic             sof;
  logic             eof;
  logic             in_times;
  logic             in_pats;
  logic [OFF_W-1:0] rel_t;
  logic [OFF_W-1:0] rel_p;
  logic [7:0]       count_cap;
  logic [31:0]      times_cap [MAX_STAGES];
  logic [5:0]       pats_cap  [MAX_STAGES];

  assign take  = byte_en && (bytes_held != BH_W'(BUFFER_BYTES));
  assign cap   = take && start_found;
  assign sof   = !start_found && (prior_two_bytes == {MARK_S, MARK_O}) && (rx_byte == MARK_F);
  assign eof   = (prior_two_bytes == {MARK_E, MARK_O}) && (rx_byte == MARK_F);
  assign rel_t = payload_offset - OFF_W'(TIMES_START);
  assign rel_p = payload_offset - OFF_W'(PAT_START);
  assign in_times = (payload_offset >= OFF_W'(TIMES_START)) &&
                    (payload_offset < OFF_W'(PAT_START));
  assign in_pats  = (payload_offset >= OFF_W'(PAT_START)) &&
                    (payload_offset < OFF_W'(PAYLOAD_END));

  assign count_cap = (cap && (payload_offset == OFF_W'(COUNT_OFFSET))) ? rx_byte
                                                                        : pending_count;

  always_comb begin
    for (int k = 0; k < MAX_STAGES; k++) begin
      times_cap[k] = pending_times[k];
      pats_cap[k]  = pending_patterns[k];
      if (cap && in_times && ((rel_t >> 2) == OFF_W'(k))) begin
        for (int j = 0; j < 4; j++) begin
          if (rel_t[1:0] == 2'(3 - j)) begin
            times_cap[k][8*j +: 8] = pending_times[k][8*j +: 8] | rx_byte;
          end
        end
      end
      if (cap && in_pats && ((rel_p >> 2) == OFF_W'(k))) begin
        if (rel_p[1:0] == 2'd2) begin
          pats_cap[k] = pending_patterns[k] | {rx_byte[3:0], 2'b00};
        end else if (rel_p[1:0] == 2'd3) begin
          pats_cap[k] = pending_patterns[k] | {4'b0000, rx_byte[7:6]};
        end
      end
    end
  end

  always_comb begin
    evt.load   = take && eof && start_found;
    evt.status = FS_NONE;
    if (take && eof) begin
      evt.status = start_found ? FS_LOADED : FS_NO_SOF;
    end
    load_count = (count_cap > 8'(MAX_STAGES)) ? CNT_W'(MAX_STAGES) : count_cap[CNT_W-1:0];
    load_times    = times_cap;
    load_patterns = pats_cap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held      <= '0;
      prior_two_bytes <= '0;
      start_found     <= 1'b0;
      payload_offset  <= '0;
      pending_count   <= '0;
      for (int k = 0; k < MAX_STAGES; k++) begin
        pending_times[k]    <= '0;
        pending_patterns[k] <= '0;
      end
    end else if (take) begin
      if (eof) begin
        bytes_held      <= '0;
        prior_two_bytes <= '0;
        start_found     <= 1'b0;
        payload_offset  <= '0;
        pending_count   <= '0;
        for (int k = 0; k < MAX_STAGES; k++) begin
          pending_times[k]    <= '0;
          pending_patterns[k] <= '0;
        end
      end else begin
        bytes_held      <= bytes_held + 1'b1;
        prior_two_bytes <= {prior_two_bytes[7:0], rx_byte};
        pending_count   <= count_cap;
        pending_times    <= times_cap;
        pending_patterns <= pats_cap;
        if (sof) begin
          start_found    <= 1'b1;
          payload_offset <= '0;
        end else if (cap && (payload_offset < OFF_W'(PAYLOAD_END))) begin
          payload_offset <= payload_offset + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/fsss_stage.sv =====
module fsss_stage
  import fsss_pkg::*;
#(
  parameter int MAX_STAGES = MAX_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick_en,
  input  logic                              load_en,
  input  logic [$clog2(MAX_STAGES+1)-1:0]   load_count,
  input  logic [31:0]                       load_times    [MAX_STAGES],
  input  logic [5:0]                        load_patterns [MAX_STAGES],
  output logic [5:0]                        lights,
  output logic [2:0]                        stage,
  output logic                              started,
  output logic                              loaded
);

  localparam int CNT_W = $clog2(MAX_STAGES + 1);
  localparam int ST_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  logic [CNT_W-1:0] active_count;
  logic [31:0]      active_times    [MAX_STAGES];
  logic [5:0]       active_patterns [MAX_STAGES];
  logic             schedule_valid;
  logic [ST_W-1:0]  current_stage;
  logic [31:0]      time_left;
  logic             stage_running;
  logic [5:0]       lights_out;

  logic             schedule_valid_next;
  logic [ST_W-1:0]  current_stage_next;
  logic [31:0]      time_left_next;
  logic             stage_running_next;
  logic [5:0]       lights_out_next;

  logic [ST_W:0]    adv_sum;
  logic [ST_W-1:0]  adv_stage;
  logic [ST_W-1:0]  sel;
  logic [31:0]      tl_dec;

  always_comb begin
    adv_sum   = {1'b0, current_stage} + 1'b1;
    adv_stage = (adv_sum >= (ST_W+1)'(active_count)) ? '0 : adv_sum[ST_W-1:0];
    tl_dec    = time_left - 32'(time_left != 32'd0);
    sel       = stage_running ? adv_stage : current_stage;

    schedule_valid_next = schedule_valid || load_en;
    current_stage_next  = current_stage;
    time_left_next      = time_left;
    stage_running_next  = stage_running;
    lights_out_next     = lights_out;
    started             = 1'b0;

    if (tick_en) begin
      if (!schedule_valid || (active_count == '0)) begin
        stage_running_next = 1'b0;
      end else if (!stage_running || (tl_dec == 32'd0)) begin
        current_stage_next = sel;
        lights_out_next    = active_patterns[sel];
        time_left_next     = active_times[sel];
        stage_running_next = 1'b1;
        started            = 1'b1;
      end else begin
        time_left_next = tl_dec;
      end
    end

    lights = lights_out_next;
    stage  = 3'(current_stage_next);
    loaded = schedule_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count   <= '0;
      schedule_valid <= 1'b0;
      current_stage  <= '0;
      time_left      <= '0;
      stage_running  <= 1'b0;
      lights_out     <= '0;
      for (int k = 0; k < MAX_STAGES; k++) begin
        active_times[k]    <= '0;
        active_patterns[k] <= '0;
      end
    end else begin
      schedule_valid <= schedule_valid_next;
      current_stage  <= current_stage_next;
      time_left      <= time_left_next;
      stage_running  <= stage_running_next;
      lights_out     <= lights_out_next;
      if (load_en) begin
        active_count <= load_count;
        for (int k = 0; k < MAX_STAGES; k++) begin
          active_times[k]    <= (load_times[k] == 32'd0) ? 32'd1 : load_times[k];
          active_patterns[k] <= load_patterns[k];
        end
      end
    end
  end

endmodule

// ===== sv/fsss_skid.sv =====
module fsss_skid
  import fsss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  fsss_result_t push_data,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output fsss_result_t out_data
);

  logic         skid_valid;
  fsss_result_t skid_data;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== sv/framed_schedule_stage_sequencer_top.sv =====
// Framed schedule stage sequencer.
// Input channel in_valid/in_ready/in_data carries one request per item: a
// received serial byte (operation 0) or a one millisecond tick (operation 1).
// Bytes are collected into a frame; the first start marker begins positional
// capture of the stage count, stage times and light patterns, and an end
// marker loads the captured schedule or reports a missing start marker.
// Ticks step through the loaded stages and drive six lights.
// Every request yields exactly one result on out_valid/out_ready/out_data.
// Results are registered, not combinational, on the way to out_data.
// Throughput: one request per cycle while in_ready is high; all state updates
// for a request settle in the cycle it is accepted, and a two-entry output
// buffer takes one more request while the receiver holds out_ready low.
// in_ready drops only when both output entries are full and comes back the
// cycle after the receiver takes a result.
// Reset (rst, synchronous) clears the frame, the schedule, the stage index
// and the lights; no result is pending after reset.
module framed_schedule_stage_sequencer_top
  import fsss_pkg::*;
#(
  parameter int MAX_STAGES   = MAX_STAGES_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  fsss_req_t    in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output fsss_result_t out_data
);

  localparam int CNT_W = $clog2(MAX_STAGES + 1);

  logic             accept;
  logic             byte_en;
  logic             tick_en;
  fsss_frame_evt_t  evt;
  logic [CNT_W-1:0] load_count;
  logic [31:0]      load_times    [MAX_STAGES];
  logic [5:0]       load_patterns [MAX_STAGES];
  fsss_result_t     result;
  logic             sched_loaded;

  assign accept  = in_valid && in_ready;
  assign byte_en = accept && (in_data.operation == OP_BYTE);
  assign tick_en = accept && (in_data.operation == OP_TICK);

  fsss_frame #(
    .MAX_STAGES   (MAX_STAGES),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .byte_en       (byte_en),
    .rx_byte       (in_data.rx_byte),
    .evt           (evt),
    .load_count    (load_count),
    .load_times    (load_times),
    .load_patterns (load_patterns)
  );

  fsss_stage #(
    .MAX_STAGES (MAX_STAGES)
  ) u_stage (
    .clk           (clk),
    .rst           (rst),
    .tick_en       (tick_en),
    .load_en       (evt.load),
    .load_count    (load_count),
    .load_times    (load_times),
    .load_patterns (load_patterns),
    .lights        (result.light_pattern),
    .stage         (result.stage_index),
    .started       (result.stage_started),
    .loaded        (sched_loaded)
  );

  assign result.frame_status    = evt.status;
  assign result.schedule_loaded = sched_loaded;

  fsss_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("request held off while output register empty");

  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(result.stage_started && (result.frame_status != FS_NONE)))
    else $error("stage start and frame status on one request");

  a_load_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && (result.frame_status == FS_LOADED)) |-> result.schedule_loaded)
    else $error("schedule load reported without loaded flag");

  a_loaded_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(sched_loaded) && !$past(rst) |-> sched_loaded)
    else $error("loaded flag dropped");
`endif

endmodule
